[sv/lr_pkg.sv]
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer: item structs, command
// and quadrant codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DIM_BITS    = COORD_BITS + 1;
  localparam int ADDR_BITS   = 26;
  localparam int COLOR_BITS  = 32;
  localparam int RGB_BITS    = 24;
  localparam int BPP_BITS    = 3;
  localparam int REG_IDX_BITS = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH    = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  localparam logic [DIM_BITS-1:0] RST_SCREEN_WIDTH    = 13'd1024;
  localparam logic [DIM_BITS-1:0] RST_SCREEN_HEIGHT   = 13'd768;
  localparam logic [BPP_BITS-1:0] RST_BYTES_PER_PIXEL = 3'd4;
  localparam logic [BPP_BITS-1:0] BPP_24BIT           = 3'd3;

  // walk direction pairs: primary move on error >= 0, secondary otherwise
  typedef enum logic [1:0] {
    Q_RD = 2'd0,  // x+1 / y+1
    Q_DL = 2'd1,  // y+1 / x-1
    Q_LU = 2'd2,  // x-1 / y-1
    Q_UR = 2'd3   // y-1 / x+1
  } quad_t;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  byte_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  on_screen;
    logic                  last;
  } out_item_t;

  // classified command as queued between front and back
  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIM_BITS-1:0]   steps;
    quad_t                 quad;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

  // pixel leaving the walker
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  on_screen;
    logic                  last;
  } pix_t;

endpackage

[sv/lr_front.sv]
// ----------------------------------------------------------------------------
// lr_front
// Accepts input items and classifies start commands: deltas, step count
// and walk quadrant, then pushes the command into the queue.
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
(
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     q_ready,
  output logic     q_push,
  output cmd_t     q_entry
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  quad_t                 quad;

  always_comb begin
    dx = (in_data.x_end >= in_data.x_start) ? in_data.x_end - in_data.x_start
                                            : in_data.x_start - in_data.x_end;
    dy = (in_data.y_end >= in_data.y_start) ? in_data.y_end - in_data.y_start
                                            : in_data.y_start - in_data.y_end;
    if (in_data.x_end == in_data.x_start) begin
      quad = (in_data.y_end >= in_data.y_start) ? Q_DL : Q_UR;
    end else if (in_data.x_end > in_data.x_start) begin
      quad = (in_data.y_end >= in_data.y_start) ? Q_RD : Q_UR;
    end else begin
      quad = (in_data.y_end > in_data.y_start) ? Q_DL : Q_LU;
    end
  end

  assign in_stall = !q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_entry.cmd   = in_data.command;
    q_entry.x0    = in_data.x_start;
    q_entry.y0    = in_data.y_start;
    q_entry.dx    = dx;
    q_entry.dy    = dy;
    q_entry.steps = {1'b0, dx} + {1'b0, dy};
    q_entry.quad  = quad;
    q_entry.color = in_data.line_color;
  end

endmodule

[sv/lr_queue.sv]
// ----------------------------------------------------------------------------
// lr_queue
// Small command queue between the front and the walker.
// ----------------------------------------------------------------------------
module lr_queue
  import lr_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign ready     = (count_r != CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push && ready;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/lr_back.sv]
// ----------------------------------------------------------------------------
// lr_back
// Line walker: holds the active line, takes queued commands and steps the
// error term, producing one pixel per step with clipping and last flag.
// ----------------------------------------------------------------------------
module lr_back
  import lr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_data,
  output logic                q_pop,
  input  logic                bpp3,
  input  logic [DIM_BITS-1:0] scr_w,
  input  logic [DIM_BITS-1:0] scr_h,
  output logic                pix_valid,
  output pix_t                pix_data,
  input  logic                pix_ready
);

  logic [COORD_BITS-1:0]      cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]      cur_y_r, cur_y_nxt;
  logic signed [DIM_BITS-1:0] err_r, err_nxt;
  logic [COORD_BITS-1:0]      dx_r, dx_nxt;
  logic [COORD_BITS-1:0]      dy_r, dy_nxt;
  logic [DIM_BITS-1:0]        steps_r, steps_nxt;
  quad_t                      quad_r, quad_nxt;
  logic [COLOR_BITS-1:0]      color_r, color_nxt;
  logic                       pix_v_r, pix_v_nxt;
  pix_t                       pix_r, pix_nxt;
  logic                       slot_free;
  logic                       emit;
  logic                       up;
  logic signed [DIM_BITS-1:0] sdx, sdy;

  assign slot_free = !pix_v_r || pix_ready;
  assign up        = !err_r[DIM_BITS-1];
  assign sdx       = $signed({1'b0, dx_r});
  assign sdy       = $signed({1'b0, dy_r});

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    err_nxt   = err_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    steps_nxt = steps_r;
    quad_nxt  = quad_r;
    color_nxt = color_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    if (q_valid) begin
      if (q_data.cmd == CMD_START) begin
        q_pop     = 1'b1;
        cur_x_nxt = q_data.x0;
        cur_y_nxt = q_data.y0;
        err_nxt   = '0;
        dx_nxt    = q_data.dx;
        dy_nxt    = q_data.dy;
        steps_nxt = q_data.steps;
        quad_nxt  = q_data.quad;
        color_nxt = q_data.color;
      end else if (steps_r == '0) begin
        // step with no active line is dropped
        q_pop = 1'b1;
      end else if (slot_free) begin
        q_pop     = 1'b1;
        emit      = 1'b1;
        steps_nxt = steps_r - 1'b1;
        case (quad_r)
          Q_RD: begin
            if (up) begin
              cur_x_nxt = cur_x_r + 1'b1;
              err_nxt   = err_r - sdy;
            end else begin
              cur_y_nxt = cur_y_r + 1'b1;
              err_nxt   = err_r + sdx;
            end
          end
          Q_DL: begin
            if (up) begin
              cur_y_nxt = cur_y_r + 1'b1;
              err_nxt   = err_r - sdx;
            end else begin
              cur_x_nxt = cur_x_r - 1'b1;
              err_nxt   = err_r + sdy;
            end
          end
          Q_LU: begin
            if (up) begin
              cur_x_nxt = cur_x_r - 1'b1;
              err_nxt   = err_r - sdy;
            end else begin
              cur_y_nxt = cur_y_r - 1'b1;
              err_nxt   = err_r + sdx;
            end
          end
          default: begin
            if (up) begin
              cur_y_nxt = cur_y_r - 1'b1;
              err_nxt   = err_r - sdx;
            end else begin
              cur_x_nxt = cur_x_r + 1'b1;
              err_nxt   = err_r + sdy;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    pix_nxt   = pix_r;
    pix_v_nxt = pix_v_r;
    if (emit) begin
      pix_v_nxt         = 1'b1;
      pix_nxt.x         = cur_x_r;
      pix_nxt.y         = cur_y_r;
      pix_nxt.color     = bpp3 ? {{(COLOR_BITS - RGB_BITS){1'b0}}, color_r[RGB_BITS-1:0]}
                               : color_r;
      pix_nxt.on_screen = (DIM_BITS'(cur_x_r) < scr_w) && (DIM_BITS'(cur_y_r) < scr_h);
      pix_nxt.last      = (steps_r == DIM_BITS'(1));
    end else if (pix_ready) begin
      pix_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      pix_v_r <= 1'b0;
    end else begin
      steps_r <= steps_nxt;
      pix_v_r <= pix_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    err_r   <= err_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    quad_r  <= quad_nxt;
    color_r <= color_nxt;
    pix_r   <= pix_nxt;
  end

  assign pix_valid = pix_v_r;
  assign pix_data  = pix_r;

`ifndef ASSERT_OFF
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (steps_r == $past(steps_r) - 1'b1))
    else $error("step count did not drop by one on a pixel");

  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_pop && q_data.cmd == CMD_START) |=>
      (steps_r == $past(q_data.steps) && err_r == '0))
    else $error("start command did not load the line");

  a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_v_r && !pix_ready) |=> (pix_v_r && $stable(pix_r)))
    else $error("pending pixel changed while stalled");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (steps_r != '0 && q_data.cmd == CMD_STEP))
    else $error("pixel emitted without an active line");
`endif

endmodule

[sv/lr_addr.sv]
// ----------------------------------------------------------------------------
// lr_addr
// Framebuffer address pipeline: row times stride plus column, then scaled
// by the pixel size, ending in the output register.
// ----------------------------------------------------------------------------
module lr_addr
  import lr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bpp3,
  input  logic [DIM_BITS-1:0] scr_w,
  input  logic                pix_valid,
  input  pix_t                pix_data,
  output logic                pix_ready,
  output logic                out_valid,
  output out_item_t           out_data,
  input  logic                out_stall
);

  logic                          a_v_r, a_v_nxt;
  pix_t                          a_pix_r;
  logic [ADDR_BITS-1:0]          a_lin_r;
  logic [COORD_BITS+DIM_BITS-1:0] prod;
  logic                          o_v_r, o_v_nxt;
  out_item_t                     o_r;
  logic                          o_free;
  logic                          a_load;
  logic                          o_load;
  logic [ADDR_BITS-1:0]          addr;

  assign o_free    = !o_v_r || !out_stall;
  assign pix_ready = !a_v_r || o_free;
  assign a_load    = pix_valid && pix_ready;
  assign o_load    = a_v_r && o_free;

  assign prod = pix_data.y * scr_w;
  // 3 bytes: lin*2 + lin, any other size: lin*4
  assign addr = bpp3 ? ({a_lin_r[ADDR_BITS-2:0], 1'b0} + a_lin_r)
                     : {a_lin_r[ADDR_BITS-3:0], 2'b00};

  always_comb begin
    a_v_nxt = a_v_r;
    if (a_load) begin
      a_v_nxt = 1'b1;
    end else if (o_free) begin
      a_v_nxt = 1'b0;
    end
    o_v_nxt = o_v_r;
    if (o_load) begin
      o_v_nxt = 1'b1;
    end else if (!out_stall) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_pix_r <= pix_data;
      a_lin_r <= ADDR_BITS'(prod) + ADDR_BITS'(pix_data.x);
    end
    if (o_load) begin
      o_r.pixel_x      <= a_pix_r.x;
      o_r.pixel_y      <= a_pix_r.y;
      o_r.byte_address <= addr;
      o_r.pixel_color  <= a_pix_r.color;
      o_r.on_screen    <= a_pix_r.on_screen;
      o_r.last         <= a_pix_r.last;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

[sv/line_rasterizer_with_pixel_address.sv]
// A step item passes the queue, the walker, the address and output registers.
// Throughput while not stalled: one item per cycle; the walker does one error
// update and the address pipeline (multiply, then scale) one pixel per cycle.
// Start items and steps with no active line produce no result.
// Reset: synchronous, clears the queue, the active line and the output,
// and sets the screen to 1024x768 at 4 bytes per pixel.
// ----------------------------------------------------------------------------
// line_rasterizer_with_pixel_address
// Four-connected line walker with clipping and framebuffer byte address.
// ----------------------------------------------------------------------------
module line_rasterizer_with_pixel_address
  import lr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  in_item_t                in_data,
  output logic                    in_stall,
  output logic                    out_valid,
  output out_item_t               out_data,
  input  logic                    out_stall,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  logic [DIM_BITS-1:0] scr_w_r, scr_w_nxt;
  logic [DIM_BITS-1:0] scr_h_r, scr_h_nxt;
  logic [BPP_BITS-1:0] bpp_r, bpp_nxt;
  logic                bpp3;

  logic q_ready, q_push, q_pop, q_valid;
  cmd_t q_entry, q_head;
  logic pix_valid, pix_ready;
  pix_t pix_data;

  assign cfg_ready = 1'b1;
  assign bpp3      = (bpp_r == BPP_24BIT);

  always_comb begin
    scr_w_nxt = scr_w_r;
    scr_h_nxt = scr_h_r;
    bpp_nxt   = bpp_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:    scr_w_nxt = cfg_data;
        REG_SCREEN_HEIGHT:   scr_h_nxt = cfg_data;
        REG_BYTES_PER_PIXEL: bpp_nxt   = cfg_data[BPP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RST_SCREEN_WIDTH;
      scr_h_r <= RST_SCREEN_HEIGHT;
      bpp_r   <= RST_BYTES_PER_PIXEL;
    end else begin
      scr_w_r <= scr_w_nxt;
      scr_h_r <= scr_h_nxt;
      bpp_r   <= bpp_nxt;
    end
  end

  lr_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  lr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .ready     (q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_head)
  );

  lr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .bpp3      (bpp3),
    .scr_w     (scr_w_r),
    .scr_h     (scr_h_r),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .pix_ready (pix_ready)
  );

  lr_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .bpp3      (bpp3),
    .scr_w     (scr_w_r),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .pix_ready (pix_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
